>>> rtl/fcrs_pkg.sv
package fcrs_pkg;

  // Default number of frequency table entries.
  localparam int MAX_STATES_DEF = 16;

  // Widths fixed by the item and register formats.
  localparam int FREQ_W = 32;
  localparam int NUM_STATES_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 72;
  localparam int IN_USER_W = 3;
  localparam int OUT_USER_W = 3;

  // Register values after reset.
  localparam logic [NUM_STATES_W-1:0] NUM_STATES_RST = 5'd1;
  localparam logic [FREQ_W-1:0] INITIAL_FREQ_RST = 32'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_FREQ = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_ABSENT = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef enum logic [2:0] {
    CMD_LOAD = 3'd0,
    CMD_REQUEST = 3'd1,
    CMD_SUSPEND = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_RD_TIME = 3'd4,
    CMD_RD_TRANS = 3'd5,
    CMD_RD_TOTAL = 3'd6
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_GO_TO,
    ST_GO_FROM,
    ST_WAIT,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_FINAL,
    ST_RD_WAIT,
    ST_DONE
  } fsm_state_t;

  // Status of the table search unit, valid in the cycle that done is high.
  typedef struct packed {
    logic done;
    logic found;
  } srch_stat_t;

endpackage

>>> rtl/fcrs_search.sv
module fcrs_search #(
  parameter int MAX_STATES = fcrs_pkg::MAX_STATES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fcrs_pkg::FREQ_W-1:0]   key,
  input  logic [$clog2(MAX_STATES+1)-1:0] n_use,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_STATES)-1:0] wr_addr,
  input  logic [fcrs_pkg::FREQ_W-1:0]   wr_data,
  output fcrs_pkg::srch_stat_t          stat,
  output logic [$clog2(MAX_STATES)-1:0] hit_idx
);

  localparam int IW = $clog2(MAX_STATES);
  localparam int NW = $clog2(MAX_STATES+1);

  logic [fcrs_pkg::FREQ_W-1:0] tbl_mem [MAX_STATES];
  logic [fcrs_pkg::FREQ_W-1:0] tbl_rd_r;
  logic [fcrs_pkg::FREQ_W-1:0] key_r;
  logic [NW-1:0] n_r;
  logic [IW-1:0] scan_r;
  logic [IW-1:0] scan_nxt;
  logic busy_r;
  logic busy_nxt;
  logic [IW-1:0] raddr;
  logic hit;
  logic last;
  logic empty;
  logic done;

  // The table read is registered, so the address for the next entry is
  // presented in the cycle before its compare.
  assign hit = (tbl_rd_r == key_r);
  assign last = ((NW'(scan_r) + NW'(1)) == n_r);
  assign empty = (n_r == '0);
  assign done = busy_r && (empty || hit || last);

  always_comb begin
    busy_nxt = busy_r;
    scan_nxt = scan_r;
    raddr = scan_r + IW'(1);
    if (start) begin
      busy_nxt = 1'b1;
      scan_nxt = '0;
      raddr = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      scan_nxt = scan_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    if (start) begin
      key_r <= key;
      n_r <= n_use;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    tbl_rd_r <= tbl_mem[raddr];
  end

  assign stat.done = done;
  assign stat.found = done && !empty && hit;
  assign hit_idx = scan_r;

endmodule

>>> rtl/frequency_clamp_and_residency_stats.sv
// A load, resume or total read goes from decode to the output register; a counter read adds a
// registered memory read; a request runs one or two sequential table searches and a suspend
// at most one, each over up to N entries in use on one comparator.
// One item is in work at a time; back-pressure on the output holds it longer.
// Reset (synchronous, rst_n low) clears all counters by a pass over the transition matrix,
// during which no input transfer is taken.
module frequency_clamp_and_residency_stats #(
  parameter int MAX_STATES = fcrs_pkg::MAX_STATES_DEF
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                              in_tvalid,
  output logic                              in_tready,
  // value [31:0], index_from [35:32], index_to [39:36], now [71:40]
  input  logic [fcrs_pkg::IN_DATA_W-1:0]    in_tdata,
  // command [2:0]
  input  logic [fcrs_pkg::IN_USER_W-1:0]    in_tuser,

  output logic                              out_tvalid,
  input  logic                              out_tready,
  // data [31:0]
  output logic [fcrs_pkg::FREQ_W-1:0]       out_tdata,
  // clamped_high [0], status [2:1]
  output logic [fcrs_pkg::OUT_USER_W-1:0]   out_tuser,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcrs_pkg::FREQ_W-1:0]       cfg_data
);

  localparam int IW = $clog2(MAX_STATES);
  localparam int NW = $clog2(MAX_STATES+1);
  localparam int CW = (NW > fcrs_pkg::NUM_STATES_W) ? NW : fcrs_pkg::NUM_STATES_W;
  localparam int MD = MAX_STATES * MAX_STATES;
  localparam int MW = $clog2(MD);
  localparam int FW = fcrs_pkg::FREQ_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never stalls. The initial frequency
  // register is not stored: current_freq takes the fixed INITIAL_FREQ_RST at
  // reset, so a write to it is taken and has no effect.
  // ---------------------------------------------------------------------------
  logic [fcrs_pkg::NUM_STATES_W-1:0] num_states_r;
  logic [FW-1:0] min_freq_r;
  logic [FW-1:0] max_freq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r <= fcrs_pkg::NUM_STATES_RST;
      min_freq_r <= '0;
      max_freq_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fcrs_pkg::CFG_NUM_STATES: num_states_r <= cfg_data[fcrs_pkg::NUM_STATES_W-1:0];
        fcrs_pkg::CFG_MIN_FREQ: min_freq_r <= cfg_data;
        fcrs_pkg::CFG_MAX_FREQ: max_freq_r <= cfg_data;
        fcrs_pkg::CFG_INITIAL_FREQ: begin
        end
      endcase
    end
  end

  // Entries in use: num_states saturated at the table depth.
  logic [CW-1:0] n_cw;
  logic [NW-1:0] n_use;

  assign n_cw = (CW'(num_states_r) > CW'(MAX_STATES)) ? CW'(MAX_STATES) : CW'(num_states_r);
  assign n_use = NW'(n_cw);

  // ---------------------------------------------------------------------------
  // Sequencer registers.
  // ---------------------------------------------------------------------------
  fcrs_pkg::fsm_state_t state_r, state_nxt;
  fcrs_pkg::cmd_t cmd_r, cmd_nxt;
  logic [FW-1:0] val_r, val_nxt;
  logic [3:0] ia_r, ia_nxt;
  logic [3:0] ib_r, ib_nxt;
  logic [FW-1:0] now_r, now_nxt;
  logic hi_r, hi_nxt;
  logic [1:0] st_r, st_nxt;
  logic [FW-1:0] data_r, data_nxt;
  logic [IW-1:0] to_idx_r, to_idx_nxt;
  logic [IW-1:0] from_idx_r, from_idx_nxt;
  logic from_found_r, from_found_nxt;
  logic phase_from_r, phase_from_nxt;
  logic [FW-1:0] elapsed_r, elapsed_nxt;
  logic [MW-1:0] clr_r, clr_nxt;

  // Architectural state.
  logic [FW-1:0] total_r, total_nxt;
  logic [FW-1:0] current_r, current_nxt;
  logic [FW-1:0] last_r, last_nxt;
  logic suspended_r, suspended_nxt;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  logic [FW-1:0] out_data_r, out_data_nxt;
  logic out_hi_r, out_hi_nxt;
  logic [1:0] out_st_r, out_st_nxt;

  // Search unit hookup.
  logic srch_start;
  logic [FW-1:0] srch_key;
  logic tbl_we;
  fcrs_pkg::srch_stat_t srch_stat;
  logic [IW-1:0] srch_idx;

  // Counter memories.
  logic [FW-1:0] tis_mem [MAX_STATES];
  logic [FW-1:0] mtx_mem [MD];
  logic [FW-1:0] tis_rd_r;
  logic [FW-1:0] mtx_rd_r;
  logic tis_we;
  logic mtx_we;
  logic [IW-1:0] tis_raddr;
  logic [IW-1:0] tis_waddr;
  logic [FW-1:0] tis_wdata;
  logic [MW-1:0] mtx_addr;
  logic [MW-1:0] mtx_waddr;
  logic [FW-1:0] mtx_wdata;

  // Helper terms.
  logic in_xfer;
  logic upd_phase;
  logic changed;
  logic [IW-1:0] ia_idx;
  logic [IW-1:0] ib_idx;
  logic [FW-1:0] clamp_val;
  logic clamp_hi;

  assign in_tready = (state_r == fcrs_pkg::ST_IDLE);
  assign in_xfer = in_tvalid && in_tready;
  assign ia_idx = IW'(ia_r);
  assign ib_idx = IW'(ib_r);
  // A request or suspend moves the block off current_freq only if the new
  // value differs; suspend searches current_freq itself, so it never counts.
  assign changed = (val_r != current_r);
  assign upd_phase = (state_r == fcrs_pkg::ST_UPD_RD) || (state_r == fcrs_pkg::ST_UPD_WR);

  // Clamp to the nonzero limits; the maximum wins when both apply.
  always_comb begin
    clamp_val = val_r;
    clamp_hi = 1'b0;
    if ((min_freq_r != '0) && (val_r < min_freq_r)) begin
      clamp_val = min_freq_r;
    end
    if ((max_freq_r != '0) && (clamp_val > max_freq_r)) begin
      clamp_val = max_freq_r;
      clamp_hi = 1'b1;
    end
  end

  // Matrix cell address: row times depth plus column. During an update the
  // cell is the one just left and the one reached; otherwise the read indexes.
  always_comb begin
    if (upd_phase) begin
      mtx_addr = MW'(from_idx_r) * MW'(MAX_STATES) + MW'(to_idx_r);
    end else begin
      mtx_addr = MW'(ia_idx) * MW'(MAX_STATES) + MW'(ib_idx);
    end
  end

  assign tis_raddr = upd_phase ? from_idx_r : ia_idx;
  assign srch_key = phase_from_r ? current_r : val_r;

  // ---------------------------------------------------------------------------
  // Sequencer: next state, datapath updates and memory write enables.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    val_nxt = val_r;
    ia_nxt = ia_r;
    ib_nxt = ib_r;
    now_nxt = now_r;
    hi_nxt = hi_r;
    st_nxt = st_r;
    data_nxt = data_r;
    to_idx_nxt = to_idx_r;
    from_idx_nxt = from_idx_r;
    from_found_nxt = from_found_r;
    phase_from_nxt = phase_from_r;
    elapsed_nxt = elapsed_r;
    clr_nxt = clr_r;
    total_nxt = total_r;
    current_nxt = current_r;
    last_nxt = last_r;
    suspended_nxt = suspended_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    out_hi_nxt = out_hi_r;
    out_st_nxt = out_st_r;
    srch_start = 1'b0;
    tbl_we = 1'b0;
    tis_we = 1'b0;
    tis_waddr = from_idx_r;
    tis_wdata = tis_rd_r + elapsed_r;
    mtx_we = 1'b0;
    mtx_waddr = mtx_addr;
    mtx_wdata = mtx_rd_r + FW'(1);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      fcrs_pkg::ST_CLEAR: begin
        mtx_we = 1'b1;
        mtx_waddr = clr_r;
        mtx_wdata = '0;
        tis_we = (clr_r < MW'(MAX_STATES));
        tis_waddr = IW'(clr_r);
        tis_wdata = '0;
        clr_nxt = clr_r + MW'(1);
        if (clr_r == MW'(MD - 1)) begin
          state_nxt = fcrs_pkg::ST_IDLE;
        end
      end

      fcrs_pkg::ST_IDLE: begin
        if (in_xfer) begin
          cmd_nxt = fcrs_pkg::cmd_t'(in_tuser);
          val_nxt = in_tdata[31:0];
          ia_nxt = in_tdata[35:32];
          ib_nxt = in_tdata[39:36];
          now_nxt = in_tdata[71:40];
          hi_nxt = 1'b0;
          st_nxt = fcrs_pkg::STAT_OK;
          data_nxt = '0;
          phase_from_nxt = 1'b0;
          state_nxt = fcrs_pkg::ST_DECODE;
        end
      end

      fcrs_pkg::ST_DECODE: begin
        state_nxt = fcrs_pkg::ST_DONE;
        unique case (cmd_r)
          fcrs_pkg::CMD_LOAD: begin
            if (CW'(ia_r) < CW'(MAX_STATES)) begin
              tbl_we = 1'b1;
            end else begin
              st_nxt = fcrs_pkg::STAT_RANGE;
            end
          end
          fcrs_pkg::CMD_REQUEST: begin
            val_nxt = clamp_val;
            hi_nxt = clamp_hi;
            state_nxt = fcrs_pkg::ST_GO_TO;
          end
          fcrs_pkg::CMD_SUSPEND: begin
            if (!suspended_r) begin
              val_nxt = current_r;
              suspended_nxt = 1'b1;
              state_nxt = fcrs_pkg::ST_GO_TO;
            end
          end
          fcrs_pkg::CMD_RESUME: begin
            if (suspended_r) begin
              last_nxt = now_r;
              suspended_nxt = 1'b0;
              if (val_r != '0) begin
                current_nxt = val_r;
              end
            end
          end
          fcrs_pkg::CMD_RD_TIME: begin
            if (CW'(ia_r) < n_cw) begin
              state_nxt = fcrs_pkg::ST_RD_WAIT;
            end else begin
              st_nxt = fcrs_pkg::STAT_RANGE;
            end
          end
          fcrs_pkg::CMD_RD_TRANS: begin
            if ((CW'(ia_r) < n_cw) && (CW'(ib_r) < n_cw)) begin
              state_nxt = fcrs_pkg::ST_RD_WAIT;
            end else begin
              st_nxt = fcrs_pkg::STAT_RANGE;
            end
          end
          fcrs_pkg::CMD_RD_TOTAL: begin
            data_nxt = total_r;
          end
          default: begin
          end
        endcase
      end

      fcrs_pkg::ST_GO_TO: begin
        srch_start = 1'b1;
        state_nxt = fcrs_pkg::ST_WAIT;
      end

      fcrs_pkg::ST_GO_FROM: begin
        srch_start = 1'b1;
        state_nxt = fcrs_pkg::ST_WAIT;
      end

      fcrs_pkg::ST_WAIT: begin
        if (srch_stat.done) begin
          if (phase_from_r) begin
            from_found_nxt = srch_stat.found;
            from_idx_nxt = srch_idx;
            state_nxt = fcrs_pkg::ST_UPD_RD;
          end else if (!srch_stat.found) begin
            st_nxt = fcrs_pkg::STAT_ABSENT;
            state_nxt = fcrs_pkg::ST_FINAL;
          end else if (!changed) begin
            // Same frequency: the entry left is the entry reached.
            to_idx_nxt = srch_idx;
            from_idx_nxt = srch_idx;
            from_found_nxt = 1'b1;
            state_nxt = fcrs_pkg::ST_UPD_RD;
          end else begin
            to_idx_nxt = srch_idx;
            phase_from_nxt = 1'b1;
            state_nxt = fcrs_pkg::ST_GO_FROM;
          end
        end
      end

      fcrs_pkg::ST_UPD_RD: begin
        elapsed_nxt = now_r - last_r;
        state_nxt = fcrs_pkg::ST_UPD_WR;
      end

      fcrs_pkg::ST_UPD_WR: begin
        tis_we = from_found_r;
        mtx_we = from_found_r && changed;
        if (changed) begin
          total_nxt = total_r + FW'(1);
        end
        last_nxt = now_r;
        state_nxt = fcrs_pkg::ST_FINAL;
      end

      fcrs_pkg::ST_FINAL: begin
        if (cmd_r == fcrs_pkg::CMD_REQUEST) begin
          current_nxt = val_r;
          data_nxt = val_r;
        end
        state_nxt = fcrs_pkg::ST_DONE;
      end

      fcrs_pkg::ST_RD_WAIT: begin
        data_nxt = (cmd_r == fcrs_pkg::CMD_RD_TIME) ? tis_rd_r : mtx_rd_r;
        state_nxt = fcrs_pkg::ST_DONE;
      end

      fcrs_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = data_r;
          out_hi_nxt = hi_r;
          out_st_nxt = st_r;
          state_nxt = fcrs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = fcrs_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcrs_pkg::ST_CLEAR;
      clr_r <= '0;
      total_r <= '0;
      current_r <= fcrs_pkg::INITIAL_FREQ_RST;
      last_r <= '0;
      suspended_r <= 1'b0;
      out_valid_r <= 1'b0;
      phase_from_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      total_r <= total_nxt;
      current_r <= current_nxt;
      last_r <= last_nxt;
      suspended_r <= suspended_nxt;
      out_valid_r <= out_valid_nxt;
      phase_from_r <= phase_from_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    val_r <= val_nxt;
    ia_r <= ia_nxt;
    ib_r <= ib_nxt;
    now_r <= now_nxt;
    hi_r <= hi_nxt;
    st_r <= st_nxt;
    data_r <= data_nxt;
    to_idx_r <= to_idx_nxt;
    from_idx_r <= from_idx_nxt;
    from_found_r <= from_found_nxt;
    elapsed_r <= elapsed_nxt;
    out_data_r <= out_data_nxt;
    out_hi_r <= out_hi_nxt;
    out_st_r <= out_st_nxt;
  end

  // Residency counters: one read and one write port, read data registered.
  always_ff @(posedge clk) begin
    if (tis_we) begin
      tis_mem[tis_waddr] <= tis_wdata;
    end
    tis_rd_r <= tis_mem[tis_raddr];
  end

  // Transition matrix, flattened row by row.
  always_ff @(posedge clk) begin
    if (mtx_we) begin
      mtx_mem[mtx_waddr] <= mtx_wdata;
    end
    mtx_rd_r <= mtx_mem[mtx_addr];
  end

  // ---------------------------------------------------------------------------
  // Frequency table and its sequential search.
  // ---------------------------------------------------------------------------
  fcrs_search #(
    .MAX_STATES(MAX_STATES)
  ) u_search (
    .clk(clk),
    .rst_n(rst_n),
    .start(srch_start),
    .key(srch_key),
    .n_use(n_use),
    .wr_en(tbl_we),
    .wr_addr(ia_idx),
    .wr_data(val_r),
    .stat(srch_stat),
    .hit_idx(srch_idx)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = {out_st_r, out_hi_r};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input taken while an item is in work");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (srch_stat.done && srch_stat.found) |-> (NW'(srch_idx) < n_use))
    else $error("search hit beyond the entries in use");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> ((total_r == $past(total_r)) || (total_r == $past(total_r) + FW'(1))))
    else $error("transition total moved by more than one");

  a_clamp_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == max_freq_r))
    else $error("clamped result differs from the maximum limit");

endmodule

>>> sim/frequency_clamp_and_residency_stats_tb.sv
`timescale 1ns / 100ps

module frequency_clamp_and_residency_stats_tb;

  localparam int TABLE_DEPTH = fcrs_pkg::MAX_STATES_DEF;
  localparam logic [2:0] CMD_RESERVED = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_REPORTS = 10;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] OFF_TABLE = 32'd12345;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [3:0]  idx_from;
    logic [3:0]  idx_to;
    logic [31:0] now;
  } freq_cmd_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] data;
    logic        clamped_high;
    logic [1:0]  status;
  } freq_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [fcrs_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [fcrs_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [fcrs_pkg::FREQ_W-1:0]     out_tdata;
  logic [fcrs_pkg::OUT_USER_W-1:0] out_tuser;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [fcrs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fcrs_pkg::FREQ_W-1:0]     cfg_data = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  frequency_clamp_and_residency_stats #(
    .MAX_STATES(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Commands waiting to be sent, and replies owed by the block in order.
  freq_cmd_t   pending_cmds[$];
  freq_reply_t expected_replies[$];

  // Shadow of the block: configuration registers and statistics.
  logic [fcrs_pkg::NUM_STATES_W-1:0] reg_num_states;
  logic [31:0] reg_min;
  logic [31:0] reg_max;
  logic [31:0] reg_initial;
  logic [31:0] freq_tbl [TABLE_DEPTH];
  logic [31:0] residency [TABLE_DEPTH];
  logic [31:0] move_count [TABLE_DEPTH][TABLE_DEPTH];
  logic [31:0] total_moves;
  logic [31:0] cur_freq;
  logic [31:0] last_stamp;
  logic        is_suspended;

  // Generator-side view of the table and the running time stamp.
  logic [31:0] gen_tbl [TABLE_DEPTH];
  logic [31:0] gen_now = '0;

  logic        quiet_phase = 1'b0;
  int unsigned in_hold = 0;
  int unsigned out_hold = 0;
  int          quiet_cycles = 0;
  int          fault_count = 0;
  freq_cmd_t   in_flight;

  function automatic int active_entries();
    return (int'(reg_num_states) > TABLE_DEPTH) ? TABLE_DEPTH : int'(reg_num_states);
  endfunction

  // Lowest index holding f among the entries in use, or -1 when absent.
  function automatic int find_freq(logic [31:0] f);
    int n;
    n = active_entries();
    for (int i = 0; i < n; i++)
      if (freq_tbl[i] == f)
        return i;
    return -1;
  endfunction

  // Charges residency to the frequency being left and counts the move.
  function automatic logic [1:0] account_move(logic [31:0] f, logic [31:0] stamp);
    int to_idx;
    int from_idx;
    to_idx = find_freq(f);
    if (to_idx < 0)
      return fcrs_pkg::STAT_ABSENT;
    from_idx = find_freq(cur_freq);
    if (from_idx >= 0)
      residency[from_idx] += stamp - last_stamp;
    if (f != cur_freq) begin
      if (from_idx >= 0)
        move_count[from_idx][to_idx] += 32'd1;
      total_moves += 32'd1;
    end
    last_stamp = stamp;
    return fcrs_pkg::STAT_OK;
  endfunction

  function automatic freq_reply_t clamp_and_account(freq_cmd_t c);
    freq_reply_t r;
    logic [31:0] f;
    int n;
    r.cmd = c.cmd;
    r.data = '0;
    r.clamped_high = 1'b0;
    r.status = fcrs_pkg::STAT_OK;
    n = active_entries();
    f = c.value;
    case (c.cmd)
      fcrs_pkg::CMD_LOAD: begin
        if (int'(c.idx_from) < TABLE_DEPTH)
          freq_tbl[c.idx_from] = c.value;
        else
          r.status = fcrs_pkg::STAT_RANGE;
      end
      fcrs_pkg::CMD_REQUEST: begin
        if (reg_min != 0 && f < reg_min)
          f = reg_min;
        if (reg_max != 0 && f > reg_max) begin
          f = reg_max;
          r.clamped_high = 1'b1;
        end
        r.status = account_move(f, c.now);
        cur_freq = f;
        r.data = f;
      end
      fcrs_pkg::CMD_SUSPEND: begin
        if (!is_suspended) begin
          r.status = account_move(cur_freq, c.now);
          is_suspended = 1'b1;
        end
      end
      fcrs_pkg::CMD_RESUME: begin
        if (is_suspended) begin
          last_stamp = c.now;
          is_suspended = 1'b0;
          if (c.value != 0)
            cur_freq = c.value;
        end
      end
      fcrs_pkg::CMD_RD_TIME: begin
        if (int'(c.idx_from) < n)
          r.data = residency[c.idx_from];
        else
          r.status = fcrs_pkg::STAT_RANGE;
      end
      fcrs_pkg::CMD_RD_TRANS: begin
        if (int'(c.idx_from) < n && int'(c.idx_to) < n)
          r.data = move_count[c.idx_from][c.idx_to];
        else
          r.status = fcrs_pkg::STAT_RANGE;
      end
      fcrs_pkg::CMD_RD_TOTAL: r.data = total_moves;
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet_phase)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Index that mostly lands inside the entries in use.
  function automatic logic [3:0] pick_index();
    int n;
    n = active_entries();
    if (n > 0 && $urandom_range(0, 99) < 85)
      return 4'($urandom_range(0, n - 1));
    return 4'($urandom_range(0, TABLE_DEPTH - 1));
  endfunction

  // Frequencies are mostly table entries, with near misses, limits and extremes mixed in.
  function automatic logic [31:0] pick_freq();
    int unsigned r;
    logic [31:0] base;
    r = $urandom_range(0, 99);
    base = gen_tbl[pick_index()];
    if (r < 62)
      return base;
    if (r < 70)
      return base + 32'd1;
    if (r < 74)
      return base - 32'd1;
    if (r < 80)
      return reg_min;
    if (r < 86)
      return reg_max;
    if (r < 90)
      return 32'd0;
    if (r < 93)
      return ALL_ONES;
    return $urandom;
  endfunction

  // Time mostly moves forward in small steps; now and then a big jump wraps it.
  function automatic logic [31:0] step_clock();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80)
      gen_now += $urandom_range(1, 1000);
    else if (r < 95)
      gen_now += $urandom_range(1, 1 << 20);
    else
      gen_now += $urandom;
    return gen_now;
  endfunction

  task automatic queue_cmd(input logic [2:0] cmd, input logic [31:0] value,
                           input logic [3:0] a, input logic [3:0] b,
                           input logic [31:0] stamp);
    freq_cmd_t c;
    c.cmd = cmd;
    c.value = value;
    c.idx_from = a;
    c.idx_to = b;
    c.now = stamp;
    if (cmd == fcrs_pkg::CMD_LOAD)
      gen_tbl[a] = value;
    pending_cmds.push_back(c);
  endtask

  task automatic queue_random_cmds(input int count);
    int unsigned r;
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [3:0]  a;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      a = pick_index();
      value = $urandom;
      if (r < 44) begin
        cmd = fcrs_pkg::CMD_REQUEST;
        value = pick_freq();
      end else if (r < 50) begin
        cmd = fcrs_pkg::CMD_LOAD;
        a = 4'($urandom_range(0, TABLE_DEPTH - 1));
        // Some loads copy another entry so that duplicates appear in the table.
        if ($urandom_range(0, 99) < 30)
          value = gen_tbl[$urandom_range(0, TABLE_DEPTH - 1)];
      end else if (r < 58) begin
        cmd = fcrs_pkg::CMD_SUSPEND;
      end else if (r < 66) begin
        cmd = fcrs_pkg::CMD_RESUME;
        value = ($urandom_range(0, 1) == 0) ? 32'd0 : pick_freq();
      end else if (r < 78) begin
        cmd = fcrs_pkg::CMD_RD_TIME;
      end else if (r < 90) begin
        cmd = fcrs_pkg::CMD_RD_TRANS;
      end else if (r < 97) begin
        cmd = fcrs_pkg::CMD_RD_TOTAL;
      end else begin
        cmd = CMD_RESERVED;
      end
      queue_cmd(cmd, value, a, pick_index(), step_clock());
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || in_tvalid || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [fcrs_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do
      @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      fcrs_pkg::CFG_NUM_STATES: reg_num_states = val[fcrs_pkg::NUM_STATES_W-1:0];
      fcrs_pkg::CFG_MIN_FREQ: reg_min = val;
      fcrs_pkg::CFG_MAX_FREQ: reg_max = val;
      fcrs_pkg::CFG_INITIAL_FREQ: reg_initial = val;
      default: ;
    endcase
  endtask

  // Registers change only once every reply of the previous phase is in.
  task automatic set_regs(input logic [31:0] n, input logic [31:0] mn,
                          input logic [31:0] mx, input logic [31:0] init);
    drain();
    write_reg(fcrs_pkg::CFG_NUM_STATES, n);
    write_reg(fcrs_pkg::CFG_MIN_FREQ, mn);
    write_reg(fcrs_pkg::CFG_MAX_FREQ, mx);
    write_reg(fcrs_pkg::CFG_INITIAL_FREQ, init);
  endtask

  // Command driver: a transfer on the input side runs the command through the shadow.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_hold <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_replies.push_back(clamp_and_account(in_flight));
      if (!in_tvalid || in_tready) begin
        if (in_hold != 0) begin
          in_tvalid <= 1'b0;
          in_hold <= in_hold - 1;
        end else if (pending_cmds.size() != 0) begin
          in_flight = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {in_flight.now, in_flight.idx_to, in_flight.idx_from, in_flight.value};
          in_tuser <= in_flight.cmd;
          in_hold <= idle_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_reply();
    freq_reply_t want;
    if (expected_replies.size() == 0) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("unexpected reply: data %h tuser %b", out_tdata, out_tuser);
    end else begin
      want = expected_replies.pop_front();
      if (out_tdata !== want.data || out_tuser[0] !== want.clamped_high ||
          out_tuser[2:1] !== want.status) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("reply mismatch, command %0d: expected data %h clamped_high %b status %0d, %s",
                   want.cmd, want.data, want.clamped_high, want.status,
                   $sformatf("got data %h clamped_high %b status %0d",
                             out_tdata, out_tuser[0], out_tuser[2:1]));
      end
    end
  endtask

  // Reply monitor with random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_tvalid && out_tready)
        check_reply();
      if (out_hold != 0) begin
        out_tready <= 1'b0;
        out_hold <= out_hold - 1;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) < 30)
          out_hold <= idle_len();
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reg_num_states = fcrs_pkg::NUM_STATES_RST;
    reg_min = '0;
    reg_max = '0;
    reg_initial = fcrs_pkg::INITIAL_FREQ_RST;
    total_moves = '0;
    cur_freq = fcrs_pkg::INITIAL_FREQ_RST;
    last_stamp = '0;
    is_suspended = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      freq_tbl[i] = '0;
      gen_tbl[i] = '0;
      residency[i] = '0;
      for (int j = 0; j < TABLE_DEPTH; j++)
        move_count[i][j] = '0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one entry in use. Reads only touch counters, so they are safe
    // before the table is loaded.
    queue_cmd(fcrs_pkg::CMD_RD_TIME, 32'd0, 4'd0, 4'd0, step_clock());
    queue_cmd(fcrs_pkg::CMD_RD_TIME, 32'd0, 4'd1, 4'd0, step_clock());
    queue_cmd(fcrs_pkg::CMD_RD_TRANS, 32'd0, 4'd0, 4'd1, step_clock());
    queue_cmd(fcrs_pkg::CMD_RD_TOTAL, 32'd0, 4'd0, 4'd0, step_clock());
    queue_cmd(CMD_RESERVED, 32'd7, 4'd3, 4'd3, step_clock());
    queue_cmd(fcrs_pkg::CMD_RESUME, 32'd500, 4'd0, 4'd0, step_clock());
    // Load every entry; zero is left out so that the reset frequency is off the table.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0)
        queue_cmd(fcrs_pkg::CMD_LOAD, 32'd1, 4'(i), 4'd0, step_clock());
      else if (i == TABLE_DEPTH - 1)
        queue_cmd(fcrs_pkg::CMD_LOAD, ALL_ONES, 4'(i), 4'd0, step_clock());
      else
        queue_cmd(fcrs_pkg::CMD_LOAD, 32'd100000 * (i + 1) + $urandom_range(0, 999),
                  4'(i), 4'd0, step_clock());
    end

    // Full table, no limits. Walk through moves, suspend and resume by hand.
    set_regs(32'd16, 32'd0, 32'd0, ALL_ONES);
    queue_cmd(fcrs_pkg::CMD_REQUEST, gen_tbl[2], 4'd0, 4'd0, 32'd100);
    queue_cmd(fcrs_pkg::CMD_REQUEST, gen_tbl[5], 4'd0, 4'd0, 32'd350);
    queue_cmd(fcrs_pkg::CMD_REQUEST, gen_tbl[5], 4'd0, 4'd0, 32'd400);
    queue_cmd(fcrs_pkg::CMD_REQUEST, OFF_TABLE, 4'd0, 4'd0, 32'd500);
    queue_cmd(fcrs_pkg::CMD_REQUEST, gen_tbl[7], 4'd0, 4'd0, 32'd900);
    queue_cmd(fcrs_pkg::CMD_SUSPEND, 32'd0, 4'd0, 4'd0, 32'd1000);
    queue_cmd(fcrs_pkg::CMD_SUSPEND, 32'd0, 4'd0, 4'd0, 32'd1100);
    queue_cmd(fcrs_pkg::CMD_REQUEST, gen_tbl[1], 4'd0, 4'd0, 32'd1200);
    queue_cmd(fcrs_pkg::CMD_RESUME, 32'd0, 4'd0, 4'd0, 32'd1500);
    queue_cmd(fcrs_pkg::CMD_RESUME, gen_tbl[3], 4'd0, 4'd0, 32'd1550);
    queue_cmd(fcrs_pkg::CMD_REQUEST, OFF_TABLE, 4'd0, 4'd0, 32'd1600);
    // Suspending on a frequency that is not in the table still suspends.
    queue_cmd(fcrs_pkg::CMD_SUSPEND, 32'd0, 4'd0, 4'd0, 32'd1700);
    queue_cmd(fcrs_pkg::CMD_RESUME, gen_tbl[9], 4'd0, 4'd0, 32'hFFFF_FF00);
    // The time stamp wraps between the resume above and the request below.
    queue_cmd(fcrs_pkg::CMD_REQUEST, gen_tbl[0], 4'd0, 4'd0, 32'h0000_0100);
    queue_cmd(fcrs_pkg::CMD_REQUEST, gen_tbl[15], 4'd0, 4'd0, 32'h0000_0180);
    gen_now = 32'h0000_0200;
    queue_cmd(fcrs_pkg::CMD_RD_TIME, 32'd0, 4'd9, 4'd0, step_clock());
    queue_cmd(fcrs_pkg::CMD_RD_TRANS, 32'd0, 4'd2, 4'd5, step_clock());
    queue_cmd(fcrs_pkg::CMD_RD_TRANS, 32'd0, 4'd0, 4'd15, step_clock());
    queue_cmd(fcrs_pkg::CMD_RD_TOTAL, 32'd0, 4'd0, 4'd0, step_clock());
    queue_cmd(CMD_RESERVED, ALL_ONES, 4'hF, 4'hF, ALL_ONES);

    // Both limits inside the table: clamp low, clamp high, pass through.
    set_regs(32'd16, gen_tbl[3], gen_tbl[12], 32'd0);
    queue_cmd(fcrs_pkg::CMD_REQUEST, 32'd0, 4'd0, 4'd0, step_clock());
    queue_cmd(fcrs_pkg::CMD_REQUEST, ALL_ONES, 4'd0, 4'd0, step_clock());
    queue_cmd(fcrs_pkg::CMD_REQUEST, gen_tbl[7], 4'd0, 4'd0, step_clock());
    queue_random_cmds(170);

    // No entries in use: every search fails and every indexed read is out of range.
    set_regs(32'd0, 32'd0, 32'd0, 32'd0);
    queue_random_cmds(40);

    // A count above the table size saturates; run this phase without idling.
    set_regs(32'd31, 32'd1, ALL_ONES, ALL_ONES);
    quiet_phase = 1'b1;
    queue_random_cmds(170);

    set_regs(32'd5, 32'd0, gen_tbl[4], 32'd0);
    quiet_phase = 1'b0;
    queue_random_cmds(150);

    // Minimum above maximum: everything below the minimum ends at the maximum.
    set_regs(32'd16, gen_tbl[10], gen_tbl[2], 32'd0);
    queue_random_cmds(60);

    set_regs(32'd16, ALL_ONES, 32'd0, 32'd0);
    queue_random_cmds(40);

    set_regs(32'd12, 32'd0, 32'd0, $urandom);
    queue_random_cmds(250);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_replies.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/fcrs_pkg.sv
rtl/fcrs_search.sv
rtl/frequency_clamp_and_residency_stats.sv
sim/frequency_clamp_and_residency_stats_tb.sv
